### src/brfmw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfmw_pkg: shared types and constants of the byte ring FIFO
// Command codes, lane control bundle and fixed field widths.
// ----------------------------------------------------------------------------
package brfmw_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int LANES     = 4;
  localparam int BYTE_W    = 8;
  localparam int DATA_W    = LANES * BYTE_W;
  localparam int NUM_W     = 3;
  localparam int OFFSET_W  = 10;
  localparam int LEVEL_W   = 11;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_PUSH  = 2'd1,
    KIND_POP   = 2'd2,
    KIND_PEEK  = 2'd3
  } kind_t;

  // Per-transaction control broadcast to every byte lane
  typedef struct packed {
    logic             we;
    logic             re;
    logic [NUM_W-1:0] num;
  } lane_ctl_t;

endpackage
`default_nettype wire

### src/byte_ring_fifo_multiwidth_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_multiwidth_unit: byte-wide circular FIFO, 1 to 4 bytes wide
// Clear, push, pop and peek commands over a ring of DEPTH bytes.
// ----------------------------------------------------------------------------
// One transaction is taken per clock whenever busy is low; busy is high only
// while reset is held and in the first cycle after it, and no clearing pass
// is needed. Every transaction gives exactly one result, strobed on out_strobe
// in the cycle right after acceptance, and the rate is one per cycle.
// Results cannot be held off: the receiver must take each strobe. Storage is
// four byte banks with one row port each, so a transaction of up to four
// consecutive bytes touches each bank at most once; the ring is sized to the
// next power of two at or above DEPTH while capacity follows DEPTH exactly.
// ----------------------------------------------------------------------------
module byte_ring_fifo_multiwidth_unit
  import brfmw_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_kind,
  input  wire logic [NUM_W-1:0]    in_byte_count,
  input  wire logic                in_allow_partial,
  input  wire logic [DATA_W-1:0]   in_data_in,
  input  wire logic [OFFSET_W-1:0] in_peek_offset,
  output logic                     out_strobe,
  output logic      [NUM_W-1:0]    out_bytes_moved,
  output logic      [DATA_W-1:0]   out_data_out,
  output logic      [LEVEL_W-1:0]  out_fill_level
);

  localparam int AW   = $clog2(DEPTH);
  localparam int RING = 1 << AW;
  localparam int ROWS = RING / LANES;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > LEVEL_W) ? CW : LEVEL_W;

  kind_t          kind;
  logic           accept;
  logic           busy_r;
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [NUM_W-1:0] req_n;
  logic [NUM_W-1:0] mv_n;
  logic [CMPW-1:0]  cnt_x, space_x, req_x, off_x, avail_x, peek_sum;
  logic [CMPW-1:0]  cnt_nxt_x;
  logic [AW-1:0]  base;
  logic           do_wr, do_rd;
  lane_ctl_t      ctl;

  logic              strobe_r;
  logic [NUM_W-1:0]  moved_r;
  logic [NUM_W-1:0]  rd_num_r;
  logic [1:0]        rot_r;
  logic [LEVEL_W-1:0] fill_r;
  logic [LANES-1:0][BYTE_W-1:0] lane_bytes;

  assign kind   = kind_t'(in_kind);
  assign accept = start && !busy_r;
  assign busy   = busy_r;

  assign req_n   = (in_byte_count > NUM_W'(LANES)) ? NUM_W'(LANES) : in_byte_count;
  assign cnt_x   = CMPW'(cnt_r);
  assign space_x = CMPW'(DEPTH) - cnt_x;
  assign req_x   = CMPW'(req_n);
  assign off_x   = CMPW'(in_peek_offset);
  assign avail_x = cnt_x - off_x;
  assign peek_sum = CMPW'(rd_ptr_r) + off_x;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt_x  = cnt_x;
    mv_n       = '0;
    base       = rd_ptr_r;
    do_wr      = 1'b0;
    do_rd      = 1'b0;
    unique case (kind)
      KIND_CLEAR: begin
        wr_ptr_nxt = '0;
        rd_ptr_nxt = '0;
        cnt_nxt_x  = '0;
      end
      KIND_PUSH: begin
        if (req_x > space_x) begin
          // free space is below four here, so it fits the byte count
          mv_n = in_allow_partial ? space_x[NUM_W-1:0] : '0;
        end else begin
          mv_n = req_n;
        end
        base       = wr_ptr_r;
        do_wr      = 1'b1;
        wr_ptr_nxt = wr_ptr_r + AW'(mv_n);
        cnt_nxt_x  = cnt_x + CMPW'(mv_n);
      end
      KIND_POP: begin
        if (req_x > cnt_x) begin
          mv_n = in_allow_partial ? cnt_x[NUM_W-1:0] : '0;
        end else begin
          mv_n = req_n;
        end
        do_rd      = 1'b1;
        rd_ptr_nxt = rd_ptr_r + AW'(mv_n);
        cnt_nxt_x  = cnt_x - CMPW'(mv_n);
      end
      KIND_PEEK: begin
        if (off_x < cnt_x) begin
          mv_n = (req_x > avail_x) ? avail_x[NUM_W-1:0] : req_n;
        end
        base  = peek_sum[AW-1:0];
        do_rd = 1'b1;
      end
      default: begin
        mv_n = '0;
      end
    endcase
  end

  assign cnt_nxt = cnt_nxt_x[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      strobe_r <= accept;
      if (accept) begin
        wr_ptr_r <= wr_ptr_nxt;
        rd_ptr_r <= rd_ptr_nxt;
        cnt_r    <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      moved_r  <= mv_n;
      rd_num_r <= do_rd ? mv_n : '0;
      rot_r    <= base[1:0];
      fill_r   <= cnt_nxt_x[LEVEL_W-1:0];
    end
  end

  assign ctl.we  = accept && do_wr;
  assign ctl.re  = accept && do_rd;
  assign ctl.num = mv_n;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    brfmw_lane #(
      .LANE_ID (g),
      .AW      (AW),
      .ROWS    (ROWS),
      .RW      (RW)
    ) u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .base  (base),
      .wdata (in_data_in),
      .rdata (lane_bytes[g])
    );
  end

  brfmw_merge u_merge (
    .lane_bytes (lane_bytes),
    .rot        (rot_r),
    .num        (rd_num_r),
    .data       (out_data_out)
  );

  assign out_strobe      = strobe_r;
  assign out_bytes_moved = moved_r;
  assign out_fill_level  = fill_r;

  // Fill level never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(cnt_r) <= CMPW'(DEPTH))
    else $error("fill count exceeds capacity");

  // Every accepted transaction is answered in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted transaction without result");

  // No result without a transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept))
    else $error("result strobe without accepted transaction");

  // A refused or empty move returns zero data
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_bytes_moved == '0)) |-> (out_data_out == '0))
    else $error("nonzero data on a zero-byte result");

  // Count tracks pointer distance modulo the ring
  a_ptr_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (AW'(wr_ptr_r - rd_ptr_r) == AW'(cnt_r)))
    else $error("pointers disagree with fill count");

endmodule
`default_nettype wire

### src/brfmw_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfmw_lane: one byte bank of the ring
// Holds every ring byte whose address sits in this bank and serves the one
// byte of a transaction that falls here, write or registered read.
// ----------------------------------------------------------------------------
module brfmw_lane
  import brfmw_pkg::*;
#(
  parameter int LANE_ID = 0,
  parameter int AW      = 10,
  parameter int ROWS    = 256,
  parameter int RW      = 8
) (
  input  wire logic              clk,
  input  wire lane_ctl_t         ctl,
  input  wire logic [AW-1:0]     base,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem_r [ROWS];
  logic [1:0]        ofs;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     row_wide;
  logic [RW-1:0]     row;
  logic              active;
  logic [BYTE_W-1:0] wbyte;
  logic [BYTE_W-1:0] rdata_r;

  // Position of this bank's byte within the transaction
  assign ofs      = 2'(LANE_ID) - base[1:0];
  assign addr     = base + AW'(ofs);
  assign row_wide = addr >> 2;
  assign row      = row_wide[RW-1:0];
  assign active   = ({1'b0, ofs} < ctl.num);
  assign wbyte    = wdata[{ofs, 3'b000} +: BYTE_W];

  always_ff @(posedge clk) begin
    if (ctl.we && active) begin
      mem_r[row] <= wbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re && active) begin
      rdata_r <= mem_r[row];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### src/brfmw_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfmw_merge: lane merge
// Rotates the bank bytes back into FIFO order and zeroes unused bytes.
// ----------------------------------------------------------------------------
module brfmw_merge
  import brfmw_pkg::*;
(
  input  wire logic [LANES-1:0][BYTE_W-1:0] lane_bytes,
  input  wire logic [1:0]                   rot,
  input  wire logic [NUM_W-1:0]             num,
  output logic      [DATA_W-1:0]            data
);

  always_comb begin
    logic [1:0] bank;
    data = '0;
    for (int i = 0; i < LANES; i++) begin
      bank = rot + 2'(i);
      if (NUM_W'(i) < num) begin
        data[i*BYTE_W +: BYTE_W] = lane_bytes[bank];
      end
    end
  end

endmodule
`default_nettype wire

### tb/sv/tb_byte_ring_fifo_multiwidth_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_multiwidth_unit: self-checking bench for the byte ring FIFO
// Drives clear, push, pop and peek transactions through the start/busy port,
// predicts every result with a local ring model and compares each strobed
// result field by field. Directed corner cases come first, then a full-ring
// and pointer-wrap sequence, then level-steered random traffic.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_multiwidth_unit;
  import brfmw_pkg::*;

  localparam int FIFO_DEPTH  = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 800;

  typedef struct packed {
    bit [NUM_W-1:0]   bytes_moved;
    bit [DATA_W-1:0]  data_out;
    bit [LEVEL_W-1:0] fill_level;
  } fifo_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  kind_t               in_kind = KIND_CLEAR;
  logic [NUM_W-1:0]    in_byte_count = '0;
  logic                in_allow_partial = 1'b0;
  logic [DATA_W-1:0]   in_data_in = '0;
  logic [OFFSET_W-1:0] in_peek_offset = '0;
  logic                out_strobe;
  logic [NUM_W-1:0]    out_bytes_moved;
  logic [DATA_W-1:0]   out_data_out;
  logic [LEVEL_W-1:0]  out_fill_level;

  // Local ring model
  bit [BYTE_W-1:0]   ring_mem [FIFO_DEPTH];
  bit [OFFSET_W-1:0] ring_rd;
  bit [OFFSET_W-1:0] ring_wr;
  bit [LEVEL_W-1:0]  ring_fill;

  fifo_result_t expected_results [$];

  int  err_count;
  int  cycle_count;
  int  kind_seen [4];
  int  refused_count;
  int  peak_fill;
  int  results_checked;
  bit  gaps_on = 1'b1;

  byte_ring_fifo_multiwidth_unit #(
    .DEPTH(FIFO_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_byte_count    (in_byte_count),
    .in_allow_partial (in_allow_partial),
    .in_data_in       (in_data_in),
    .in_peek_offset   (in_peek_offset),
    .out_strobe       (out_strobe),
    .out_bytes_moved  (out_bytes_moved),
    .out_data_out     (out_data_out),
    .out_fill_level   (out_fill_level)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bit [DATA_W-1:0] ring_gather(int first, int n);
    bit [DATA_W-1:0] v;
    int i;
    v = '0;
    for (i = 0; i < n && i < LANES; i++)
      v[BYTE_W*i +: BYTE_W] = ring_mem[OFFSET_W'((first + i) % FIFO_DEPTH)];
    return v;
  endfunction

  // Applies one accepted transaction to the ring model and queues its result
  task automatic predict_cmd(input kind_t k, input bit [NUM_W-1:0] cnt, input bit part,
                             input bit [DATA_W-1:0] data, input bit [OFFSET_W-1:0] off);
    fifo_result_t res;
    int n, space, avail, i;
    res = '0;
    n = (cnt > LANES) ? LANES : int'(cnt);
    case (k)
      KIND_CLEAR: begin
        ring_rd = '0;
        ring_wr = '0;
        ring_fill = '0;
        n = 0;
      end
      KIND_PUSH: begin
        space = FIFO_DEPTH - int'(ring_fill);
        if (n > space) n = part ? space : 0;
        for (i = 0; i < n; i++) begin
          ring_mem[ring_wr] = data[BYTE_W*i +: BYTE_W];
          ring_wr = OFFSET_W'((ring_wr + 1) % FIFO_DEPTH);
        end
        ring_fill = LEVEL_W'(int'(ring_fill) + n);
      end
      KIND_POP: begin
        if (n > ring_fill) n = part ? int'(ring_fill) : 0;
        res.data_out = ring_gather(int'(ring_rd), n);
        ring_rd = OFFSET_W'((ring_rd + n) % FIFO_DEPTH);
        ring_fill = LEVEL_W'(int'(ring_fill) - n);
      end
      default: begin
        // peek ignores allow_partial; offset past the stored bytes refuses
        if (off < ring_fill) begin
          avail = int'(ring_fill) - int'(off);
          if (n > avail) n = avail;
          res.data_out = ring_gather((ring_rd + off) % FIFO_DEPTH, n);
        end else begin
          n = 0;
        end
      end
    endcase
    res.bytes_moved = NUM_W'(n);
    res.fill_level = ring_fill;
    expected_results.push_back(res);
    kind_seen[k]++;
    if (k != KIND_CLEAR && n == 0) refused_count++;
    if (ring_fill > peak_fill) peak_fill = int'(ring_fill);
  endtask

  // Sends one transaction; returns at the edge where it is accepted
  task automatic issue_cmd(input kind_t k, input bit [NUM_W-1:0] cnt, input bit part,
                           input bit [DATA_W-1:0] data, input bit [OFFSET_W-1:0] off);
    while (gaps_on && $urandom_range(99) < 13) begin
      start <= 1'b0;
      in_kind <= kind_t'($urandom_range(3));
      in_byte_count <= NUM_W'($urandom_range(7));
      in_allow_partial <= 1'($urandom_range(1));
      in_data_in <= $urandom;
      in_peek_offset <= OFFSET_W'($urandom_range(1023));
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= k;
    in_byte_count <= cnt;
    in_allow_partial <= part;
    in_data_in <= data;
    in_peek_offset <= off;
    do @(posedge clk); while (busy !== 1'b0);
    predict_cmd(k, cnt, part, data, off);
  endtask

  function automatic void report_field(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
  endfunction

  always @(posedge clk) begin : chk_results
    fifo_result_t want;
    if (rst_n && out_strobe !== 1'b0) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, actual %0d/0x%0h/%0d",
                 $time, out_bytes_moved, out_data_out, out_fill_level);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_strobe !== 1'b1) begin
          report_field("out_strobe", DATA_W'(1), DATA_W'(out_strobe));
          err_count++;
        end
        if (out_bytes_moved !== want.bytes_moved) begin
          report_field("bytes_moved", DATA_W'(want.bytes_moved), DATA_W'(out_bytes_moved));
          err_count++;
        end
        if (out_data_out !== want.data_out) begin
          report_field("data_out", want.data_out, out_data_out);
          err_count++;
        end
        if (out_fill_level !== want.fill_level) begin
          report_field("fill_level", DATA_W'(want.fill_level), DATA_W'(out_fill_level));
          err_count++;
        end
      end
    end
  end

  // Corner cases on a small fill level
  task automatic test_directed_ops();
    issue_cmd(KIND_CLEAR, 3'd0, 1'b0, 32'h0, 10'd0);
    issue_cmd(KIND_POP, 3'd1, 1'b0, 32'h0, 10'd0);          // strict pop, empty
    issue_cmd(KIND_POP, 3'd4, 1'b1, 32'h0, 10'd0);          // partial pop, empty
    issue_cmd(KIND_PEEK, 3'd4, 1'b0, 32'h0, 10'd0);         // peek, empty
    issue_cmd(KIND_PUSH, 3'd1, 1'b0, 32'hFFFF_FFFF, 10'd0);
    issue_cmd(KIND_PUSH, 3'd4, 1'b0, 32'h0000_0000, 10'd1023);
    issue_cmd(KIND_PUSH, 3'd4, 1'b1, 32'hFFFF_FFFF, 10'd0);
    issue_cmd(KIND_PUSH, 3'd0, 1'b0, 32'h1234_5678, 10'd0); // zero count
    issue_cmd(KIND_PUSH, 3'd7, 1'b0, 32'hA5C3_1E78, 10'd0); // saturates to four
    issue_cmd(KIND_PEEK, 3'd4, 1'b1, 32'h0, 10'd0);
    issue_cmd(KIND_PEEK, 3'd1, 1'b0, 32'h0, 10'd1023);      // offset far past level
    issue_cmd(KIND_PEEK, 3'd4, 1'b0, 32'h0, 10'd12);        // truncated to one byte
    issue_cmd(KIND_PEEK, 3'd2, 1'b0, 32'h0, 10'd13);        // offset at level
    issue_cmd(KIND_PEEK, 3'd0, 1'b0, 32'h0, 10'd3);
    issue_cmd(KIND_POP, 3'd5, 1'b0, 32'h0, 10'd0);
    issue_cmd(KIND_POP, 3'd0, 1'b1, 32'h0, 10'd0);
    issue_cmd(KIND_POP, 3'd6, 1'b1, 32'h0, 10'd0);
    issue_cmd(KIND_POP, 3'd4, 1'b0, 32'h0, 10'd0);
    issue_cmd(KIND_POP, 3'd2, 1'b0, 32'h0, 10'd0);          // strict refusal
    issue_cmd(KIND_POP, 3'd3, 1'b1, 32'h0, 10'd0);          // partial, one left
    issue_cmd(KIND_PUSH, 3'd3, 1'b1, 32'hDEAD_BEEF, 10'd0);
    issue_cmd(KIND_CLEAR, 3'd7, 1'b1, 32'hFFFF_FFFF, 10'd1023);
    issue_cmd(KIND_PEEK, 3'd4, 1'b1, 32'h0, 10'd0);
  endtask

  // Fill to capacity, exercise refusals at full, then drain across the wrap
  task automatic test_full_and_wrap();
    issue_cmd(KIND_CLEAR, 3'd0, 1'b0, 32'h0, 10'd0);
    issue_cmd(KIND_PUSH, 3'd3, 1'b0, $urandom, 10'd0);
    while (ring_fill < FIFO_DEPTH)
      issue_cmd(KIND_PUSH, 3'd4, 1'($urandom_range(1)), $urandom,
                OFFSET_W'($urandom_range(1023)));
    issue_cmd(KIND_PUSH, 3'd1, 1'b0, $urandom, 10'd0);
    issue_cmd(KIND_PUSH, 3'd3, 1'b1, $urandom, 10'd0);
    issue_cmd(KIND_PEEK, 3'd4, 1'b0, 32'h0, 10'd1023);
    issue_cmd(KIND_PEEK, 3'd4, 1'b1, 32'h0, 10'd1020);
    issue_cmd(KIND_POP, 3'd2, 1'b0, 32'h0, 10'd0);
    issue_cmd(KIND_PUSH, 3'd4, 1'b0, $urandom, 10'd0);      // strict, space is two
    issue_cmd(KIND_PUSH, 3'd4, 1'b1, $urandom, 10'd0);      // truncated to two
    while (ring_fill != 0) begin
      if ($urandom_range(4) == 0)
        issue_cmd(KIND_PEEK, NUM_W'($urandom_range(1, 4)), 1'($urandom_range(1)), 32'h0,
                  OFFSET_W'($urandom_range(0, ring_fill)));
      else
        issue_cmd(KIND_POP, NUM_W'($urandom_range(1, 4)), 1'b1, 32'h0, 10'd0);
    end
    issue_cmd(KIND_POP, 3'd1, 1'b0, 32'h0, 10'd0);
  endtask

  // Random traffic steered toward a moving fill target (often empty or full)
  task automatic test_random_traffic(input int n_items);
    int target, left, r, hi, idx;
    bit grow;
    kind_t k;
    bit [NUM_W-1:0] cnt;
    bit [OFFSET_W-1:0] off;
    target = 0;
    left = 0;
    for (idx = 0; idx < n_items; idx++) begin
      // one long stretch without any input gaps
      gaps_on = !(idx >= n_items / 2 && idx < n_items / 2 + 300);
      if (left == 0 || ring_fill == target) begin
        r = $urandom_range(3);
        target = (r == 0) ? 0 : (r == 1) ? FIFO_DEPTH : $urandom_range(FIFO_DEPTH);
        left = $urandom_range(50, 700);
      end
      left--;
      grow = ring_fill < target;
      r = $urandom_range(999);
      if (r < 5) k = KIND_CLEAR;
      else if (r < 700) k = grow ? KIND_PUSH : KIND_POP;
      else if (r < 840) k = grow ? KIND_POP : KIND_PUSH;
      else k = KIND_PEEK;
      cnt = NUM_W'(($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(1, 4));
      hi = (ring_fill + 2 > 1023) ? 1023 : ring_fill + 2;
      off = OFFSET_W'(($urandom_range(3) == 0) ? $urandom_range(1023) :
                      $urandom_range(0, hi));
      issue_cmd(k, cnt, 1'($urandom_range(1)), $urandom, off);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    ring_rd = '0;
    ring_wr = '0;
    ring_fill = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_full_and_wrap();
    test_random_traffic(RANDOM_ITEMS);
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d clears, %0d pushes, %0d pops, %0d peeks; %0d results checked",
             kind_seen[KIND_CLEAR], kind_seen[KIND_PUSH], kind_seen[KIND_POP],
             kind_seen[KIND_PEEK], results_checked);
    $display("Peak fill level %0d of %0d, %0d refused transactions, %0d errors",
             peak_fill, FIFO_DEPTH, refused_count, err_count);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
